/* src/ultrasonic_echo_ranger_ascii_unit_assert.svh */
// Assertion macros for the echo ranger; define ASSERT_OFF to compile them out.
`ifndef ULTRASONIC_ECHO_RANGER_ASCII_UNIT_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASCII_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Implication in the same cycle.
`define EUR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("echo ranger assertion failed");

// Implication in the next cycle.
`define EUR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("echo ranger assertion failed");

`else

`define EUR_ASSERT_IMP(lbl, ante, cons)
`define EUR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* src/eur_pkg.sv */
`default_nettype none

package eur_pkg;

  // Field and state widths
  localparam int CountW  = 16;
  localparam int TimerW  = 20;
  localparam int TrigW   = 16;
  localparam int HoldW   = 20;
  localparam int DivW    = 8;
  localparam int DvdW    = CountW + 4;
  localparam int DvdCntW = $clog2(DvdW + 1);
  localparam int CmpW    = (TimerW > HoldW) ? TimerW : HoldW;
  localparam int AddrW   = 4;
  localparam int IdxW    = 3;
  localparam int BcdN    = 4;

  // Register reset values
  localparam logic [TrigW-1:0] TrigReset = TrigW'(100);
  localparam logic [HoldW-1:0] HoldReset = HoldW'(100100);
  localparam logic [DivW-1:0]  DivReset  = DivW'(58);

  // Register indexes
  localparam logic [1:0] RegTrig = 2'd0;
  localparam logic [1:0] RegHold = 2'd1;
  localparam logic [1:0] RegDiv  = 2'd2;

  // Report characters
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiCr   = 8'd13;
  localparam logic [7:0] AsciiLf   = 8'd10;
  localparam logic [IdxW-1:0] IdxCr   = IdxW'(4);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(5);

  typedef enum logic [1:0] {
    PH_TRIG  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_COUNT = 2'd2,
    PH_HOLD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ctl_state_t;

  // One bit of a serial stream
  typedef struct packed {
    logic valid;
    logic data;
  } sbit_t;

endpackage

`default_nettype wire

/* src/ultrasonic_echo_ranger_ascii_unit.sv */
// Ordinary tick: result in the output register in the cycle after the request is taken.
// Echo-falling tick: bit-serial division feeding a serial BCD converter, then six
// bytes at one per cycle while the output is not stalled.
// One tick per cycle while out_stall is low; a report tick stalls input until it is sent.
// Synchronous active-low reset: trigger phase, zero timer and count, registers at defaults.
`default_nettype none
`include "ultrasonic_echo_ranger_ascii_unit_assert.svh"

module ultrasonic_echo_ranger_ascii_unit
  import eur_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // tick input
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_echo_level,
  // result output
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_trigger_level,
  output logic                  out_byte_valid,
  output logic [7:0]            out_text_byte,
  output logic                  out_last,
  // configuration
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [TrigW-1:0] trig_len_r;
  logic [HoldW-1:0] hold_len_r;
  logic [DivW-1:0]  div_val_r;

  ctl_state_t        state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [TimerW-1:0] timer_r, timer_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_trig_r, out_trig_nxt;
  logic              out_bv_r, out_bv_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;

  logic              accept;
  logic              out_free;
  logic              div_start;
  logic              div_busy;
  logic [DvdW-1:0]   dividend;
  logic [TimerW-1:0] t_inc;
  logic              t_sat;
  sbit_t             qbit;
  logic [BcdN-1:0][3:0] digits;
  logic [3:0]        digit_sel;
  logic              cfg_wr;

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_len_r <= TrigReset;
      hold_len_r <= HoldReset;
      div_val_r  <= DivReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegTrig: trig_len_r <= pwdata[TrigW-1:0];
        RegHold: hold_len_r <= pwdata[HoldW-1:0];
        RegDiv:  div_val_r  <= pwdata[DivW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegTrig: prdata = 32'(trig_len_r);
      RegHold: prdata = 32'(hold_len_r);
      RegDiv:  prdata = 32'(div_val_r);
      default: prdata = '0;
    endcase
  end

  // Saturating phase timer step and scaled count for the divider
  assign t_inc    = (timer_r == {TimerW{1'b1}}) ? timer_r : timer_r + TimerW'(1);
  assign t_sat    = t_inc == {TimerW{1'b1}};
  assign dividend = (DvdW'(count_r) << 3) + (DvdW'(count_r) << 1);

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // Pick the digit for the byte about to go out, thousands first
  assign digit_sel = digits[2'(2'd3 - idx_r[1:0])];

  // Next state and output register
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    timer_nxt     = timer_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_trig_nxt  = 1'b0;
    out_bv_nxt    = 1'b0;
    out_byte_nxt  = '0;
    out_last_nxt  = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          unique case (phase_r)
            PH_TRIG: begin
              out_trig_nxt = 1'b1;
              if ((CmpW'(t_inc) >= CmpW'(trig_len_r)) || t_sat) begin
                phase_nxt = PH_WAIT;
                timer_nxt = '0;
              end else begin
                timer_nxt = t_inc;
              end
            end
            PH_WAIT: begin
              if (in_echo_level) begin
                count_nxt = CountW'(1);
                phase_nxt = PH_COUNT;
              end
            end
            PH_COUNT: begin
              if (in_echo_level) begin
                if (count_r != {CountW{1'b1}}) begin
                  count_nxt = count_r + CountW'(1);
                end
              end else begin
                out_load  = 1'b0;
                div_start = 1'b1;
                timer_nxt = '0;
                phase_nxt = (hold_len_r == '0) ? PH_TRIG : PH_HOLD;
                state_nxt = ST_CONV;
              end
            end
            PH_HOLD: begin
              if ((CmpW'(t_inc) >= CmpW'(hold_len_r)) || t_sat) begin
                phase_nxt = PH_TRIG;
                timer_nxt = '0;
              end else begin
                timer_nxt = t_inc;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CONV: begin
        if (!div_busy) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_bv_nxt   = 1'b1;
          out_last_nxt = idx_r == IdxLast;
          if (idx_r == IdxLast) begin
            out_byte_nxt = AsciiLf;
            state_nxt    = ST_IDLE;
          end else if (idx_r == IdxCr) begin
            out_byte_nxt = AsciiCr;
          end else begin
            out_byte_nxt = AsciiZero + 8'(digit_sel);
          end
          idx_nxt = idx_r + IdxW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_TRIG;
      timer_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_trig_r <= out_trig_nxt;
      out_bv_r   <= out_bv_nxt;
      out_byte_r <= out_byte_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = out_trig_r;
  assign out_byte_valid    = out_bv_r;
  assign out_text_byte     = out_byte_r;
  assign out_last          = out_last_r;

  eur_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (div_val_r),
    .q_o      (qbit),
    .busy     (div_busy)
  );

  eur_bcd u_bcd (
    .clk      (clk),
    .clear    (div_start),
    .bit_i    (qbit),
    .digits_o (digits)
  );

  // Divider runs only during conversion
  `EUR_ASSERT_IMP(a_div_in_conv, div_busy, state_r == ST_CONV)
  // A report ends on line feed
  `EUR_ASSERT_IMP(a_lf_last, out_valid && out_byte_valid && out_last, out_text_byte == AsciiLf)
  // Trigger stays low on report bytes
  `EUR_ASSERT_IMP(a_trig_low, out_valid && out_byte_valid, !out_trigger_level)
  // Conversion follows an echo fall, which leaves the counting phase
  `EUR_ASSERT_NXT(a_start_phase, div_start, state_r == ST_CONV && phase_r != PH_COUNT)

endmodule

`default_nettype wire

/* src/eur_div.sv */
`default_nettype none

module eur_div
  import eur_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [DvdW-1:0] dividend,
  input  wire logic [DivW-1:0] divisor,
  output sbit_t                q_o,
  output logic                 busy
);

  logic               busy_r, busy_nxt;
  logic [DvdCntW-1:0] cnt_r, cnt_nxt;
  logic [DvdW-1:0]    dvd_r;
  logic [DivW-1:0]    rem_r, rem_nxt;
  logic [DivW-1:0]    div_r;
  logic [DivW:0]      trial;
  logic [DivW:0]      diff;
  logic               ge;

  // Restoring step: bring down one dividend bit, subtract where it fits
  always_comb begin
    trial   = {rem_r, dvd_r[DvdW-1]};
    diff    = trial - {1'b0, div_r};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? diff[DivW-1:0] : trial[DivW-1:0];
    cnt_nxt = cnt_r - DvdCntW'(1);
    busy_nxt = busy_r && (cnt_r != DvdCntW'(1));
  end

  // Hold the step count; advance one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DvdCntW'(DvdW);
      dvd_r  <= dividend;
      rem_r  <= '0;
      div_r  <= (divisor == '0) ? DivW'(1) : divisor;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      dvd_r  <= {dvd_r[DvdW-2:0], 1'b0};
      rem_r  <= rem_nxt;
    end
  end

  assign q_o.valid = busy_r;
  assign q_o.data  = ge;
  assign busy      = busy_r;

endmodule

`default_nettype wire

/* src/eur_bcd.sv */
`default_nettype none

module eur_bcd
  import eur_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 clear,
  input  wire sbit_t                bit_i,
  output logic [BcdN-1:0][3:0]      digits_o
);

  logic [BcdN-1:0][3:0] dig_r;
  logic [BcdN-1:0][3:0] adj;
  logic [BcdN-1:0][3:0] dig_nxt;

  // Correct each digit of five or more, then shift the bit in; the top
  // digit's carry drops out, which keeps the value modulo ten thousand
  always_comb begin
    for (int i = 0; i < BcdN; i++) begin
      adj[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
    dig_nxt = {adj[BcdN-1][2:0], adj[BcdN-2:0], bit_i.data};
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      dig_r <= '0;
    end else if (bit_i.valid) begin
      dig_r <= dig_nxt;
    end
  end

  assign digits_o = dig_r;

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
  import eur_pkg::*;

  // Clock, reset and block ports
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_echo_level = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_trigger_level;
  logic             out_byte_valid;
  logic [7:0]       out_text_byte;
  logic             out_last;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  // One result item as the block presents it
  typedef struct packed {
    logic       trig;
    logic       bvalid;
    logic [7:0] text;
    logic       last;
  } ranger_result_t;

  ranger_result_t ranger_results_q[$];

  // Predicted ranger state and register copies
  phase_t            ph = PH_TRIG;
  logic [TimerW-1:0] tmr = '0;
  logic [CountW-1:0] cnt = '0;
  logic [TrigW-1:0]  trig_len = TrigReset;
  logic [HoldW-1:0]  hold_len = HoldReset;
  logic [DivW-1:0]   div_reg = DivReset;

  // Run bookkeeping
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reports_checked = 0;
  int unsigned echo_goal = 1;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          quiet = 1'b0;
  bit          hold_go = 1'b0;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldOffCycles = 90;
  localparam int unsigned SettleCycles  = 30;

  ultrasonic_echo_ranger_ascii_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_echo_level     (in_echo_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger_level (out_trigger_level),
    .out_byte_valid    (out_byte_valid),
    .out_text_byte     (out_text_byte),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Free-running clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Queue one expected result item
  function automatic void push_result(input logic trig, input logic bvalid,
                                      input logic [7:0] text, input logic last);
    ranger_result_t r;
    r.trig   = trig;
    r.bvalid = bvalid;
    r.text   = text;
    r.last   = last;
    ranger_results_q.push_back(r);
  endfunction

  // Advance the phase timer, saturating; true once the phase has run its length
  function automatic bit timer_expired(input int unsigned len);
    if (tmr != '1) tmr++;
    return (32'(tmr) >= len) || (tmr == '1);
  endfunction

  // Work out the result items of one tick and advance the predicted state
  function automatic void predict_ranger_tick(input logic echo);
    int unsigned divisor;
    int unsigned range_cm;
    case (ph)
      PH_TRIG: begin
        if (timer_expired(32'(trig_len))) begin
          ph  = PH_WAIT;
          tmr = '0;
        end
        push_result(1'b1, 1'b0, 8'h00, 1'b1);
      end
      PH_WAIT: begin
        if (echo) begin
          cnt = CountW'(1);
          ph  = PH_COUNT;
        end
        push_result(1'b0, 1'b0, 8'h00, 1'b1);
      end
      PH_COUNT: begin
        if (echo) begin
          if (cnt != '1) cnt++;
          push_result(1'b0, 1'b0, 8'h00, 1'b1);
        end else begin
          divisor  = (div_reg == '0) ? 1 : 32'(div_reg);
          range_cm = ((32'(cnt) * 10) / divisor) % 10000;
          push_result(1'b0, 1'b1, AsciiZero + 8'(range_cm / 1000), 1'b0);
          push_result(1'b0, 1'b1, AsciiZero + 8'((range_cm / 100) % 10), 1'b0);
          push_result(1'b0, 1'b1, AsciiZero + 8'((range_cm / 10) % 10), 1'b0);
          push_result(1'b0, 1'b1, AsciiZero + 8'(range_cm % 10), 1'b0);
          push_result(1'b0, 1'b1, AsciiCr, 1'b0);
          push_result(1'b0, 1'b1, AsciiLf, 1'b1);
          tmr = '0;
          ph  = (hold_len == '0) ? PH_TRIG : PH_HOLD;
        end
      end
      default: begin
        if (timer_expired(32'(hold_len))) begin
          ph  = PH_TRIG;
          tmr = '0;
        end
        push_result(1'b0, 1'b0, 8'h00, 1'b1);
      end
    endcase
  endfunction

  // Pick an echo level that forms whole echoes, with some noise mixed in
  function automatic logic shaped_echo();
    case (ph)
      PH_WAIT: begin
        echo_goal = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 14);
        return ($urandom_range(0, 3) == 0);
      end
      PH_COUNT: begin
        if ($urandom_range(0, 15) == 0) return 1'($urandom_range(0, 1));
        return (32'(cnt) < echo_goal);
      end
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    ranger_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (ranger_results_q.size() == 0) begin
        $error("result with nothing expected: trigger %0d byte_valid %0d byte %0d last %0d",
               out_trigger_level, out_byte_valid, out_text_byte, out_last);
        errors++;
      end else begin
        want = ranger_results_q.pop_front();
        check_field("trigger_level", want.trig, out_trigger_level);
        check_field("byte_valid", want.bvalid, out_byte_valid);
        check_field("text_byte", want.text, out_text_byte);
        check_field("last", want.last, out_last);
        results_checked++;
        if (want.bvalid && want.last) reports_checked++;
      end
    end
  end

  // Drive out_stall: long hold-off on request, else random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_go) begin
      hold_left <= HoldOffCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else if (hold_left == 1) begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left != 1);
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no request accepted for %0d cycles", WatchdogLimit);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one tick, after an optional random gap, and wait for it to be taken
  task automatic send_tick(input logic echo);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_echo_level <= echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_ranger_tick(echo);
    ticks_sent++;
  endtask

  // Drop valid, let every expected result arrive, then let the block go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (ranger_results_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write: setup phase, access phase, then the bus idles before the task returns
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegTrig: trig_len = TrigW'(value);
      RegHold: hold_len = HoldW'(value);
      RegDiv:  div_reg  = DivW'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Advance until the ranger waits for an echo
  task automatic run_to_wait();
    while (ph != PH_WAIT)
      send_tick((ph == PH_COUNT) ? 1'b0 : 1'($urandom_range(0, 1)));
  endtask

  // One echo of the given length, closed by its falling tick
  task automatic send_echo(input int unsigned highs);
    repeat (highs) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Reset values, echo ignored during trigger, writes taking effect at once
  task automatic test_defaults();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle_block();
    write_reg(RegTrig, 32'd0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_echo(6);
    send_tick(1'b1);
    send_tick(1'b0);
    settle_block();
    write_reg(RegHold, 32'd0);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Falling tick goes straight back to trigger
  task automatic test_holdoff_zero();
    settle_block();
    write_reg(RegTrig, 32'd1);
    run_to_wait();
    send_echo(3);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Divisor of zero acts as one
  task automatic test_divisor_floor();
    settle_block();
    write_reg(RegDiv, 32'd0);
    run_to_wait();
    send_echo(7);
    settle_block();
    write_reg(RegDiv, 32'd1);
    run_to_wait();
    send_echo(5);
  endtask

  // Largest register values, cut short by later writes
  task automatic test_register_extremes();
    run_to_wait();
    settle_block();
    write_reg(RegTrig, 32'd65535);
    write_reg(RegHold, 32'd1048575);
    write_reg(RegDiv, 32'd255);
    send_echo(26);
    repeat (3) send_tick(1'b1);
    settle_block();
    write_reg(RegHold, 32'd2);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    settle_block();
    write_reg(RegTrig, 32'd2);
    send_tick(1'b0);
  endtask

  // Hold the receiver off while ticks keep coming, so the block backs up
  task automatic test_output_backpressure();
    settle_block();
    write_reg(RegTrig, 32'd1);
    write_reg(RegHold, 32'd1);
    write_reg(RegDiv, 32'd3);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (16) send_tick(shaped_echo());
  endtask

  // Random settings and shaped echoes
  task automatic test_random_traffic(input int unsigned n_ticks, input bit calm);
    settle_block();
    quiet <= calm;
    write_reg(RegTrig, $urandom_range(0, 4));
    write_reg(RegHold, $urandom_range(0, 6));
    case ($urandom_range(0, 5))
      0:       write_reg(RegDiv, 32'd0);
      1:       write_reg(RegDiv, 32'd1);
      2:       write_reg(RegDiv, 32'd255);
      default: write_reg(RegDiv, $urandom_range(1, 255));
    endcase
    repeat (n_ticks) send_tick(shaped_echo());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_holdoff_zero();
    test_divisor_floor();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic(10, 1'b0);
    test_random_traffic(10, 1'b0);
    test_random_traffic(8, 1'b1);
    settle_block();
    $display("Ranger run: %0d ticks sent, %0d results checked, %0d reports decoded",
             ticks_sent, results_checked, reports_checked);
    $display("Covered trigger and holdoff timing, divisor and register extremes, %s",
             "output back-pressure and random settings");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
